/* src/assert_macros.svh */
// Shared assertion forms for the sensor calibration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/ils_pkg.sv */
`default_nettype none

package ils_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int READING_W   = 14;
    localparam int FRAC_W      = 4;
    localparam int ADC_MAX     = 1023;
    localparam int READING_MAX = ADC_MAX * (2 ** FRAC_W);
    localparam int CFG_W       = 7;
    localparam int CFG_RESET   = 8;
    localparam int OP_W        = 2;
    localparam int PHASE_W     = 2;

    typedef logic [READING_W-1:0] t_reading;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_END_PHASE = 2'd1,
        OP_LOAD_REF  = 2'd2
    } t_op;

    typedef enum logic [PHASE_W-1:0] {
        PH_DETECT = 2'd0,
        PH_WHITE  = 2'd1,
        PH_BLACK  = 2'd2
    } t_phase;

endpackage

`default_nettype wire

/* src/ils_div.sv */
`default_nettype none

module ils_div #(
    parameter int DEN_W = 20,
    parameter int QUO_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [QUO_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_quo[QUO_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_rem;
            n_quo  = i_num;
            n_den  = i_den;
            n_cnt  = CNT_W'(QUO_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // one quotient bit per cycle
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* src/ir_line_sensor_calibrate.sv */
// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_ready      i_op, i_sample, i_phase, i_reference_value
// result    out        o_out_valid / i_out_ready    o_reading_ready .. o_reference_now
// config    in         i_cfg_we (no wait)           i_cfg_wdata
//
// A sample that completes a reading passes through ST_DIV, where the shared divider
// yields one quotient bit a cycle, then ST_UPD and ST_OUT. A phase end with readings
// skips ST_UPD; every other request goes from ST_IDLE straight to ST_OUT.
// Reset is synchronous, active low, and clears all statistics and the reference.
// A new request is taken while a finished result waits at the output; the following
// one waits until that result is taken.
`default_nettype none

module ir_line_sensor_calibrate #(
    parameter int SAMPLES_MAX = 64,
    parameter int COUNT_BITS  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ils_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ils_pkg::OP_W-1:0]      i_op,
    input  logic [ils_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [ils_pkg::PHASE_W-1:0]   i_phase,
    input  logic [ils_pkg::READING_W-1:0] i_reference_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_reading_ready,
    output logic [ils_pkg::READING_W-1:0] o_reading,
    output logic                          o_track_found,
    output logic                          o_stats_ready,
    output logic [ils_pkg::READING_W-1:0] o_stat_mean,
    output logic [ils_pkg::READING_W-1:0] o_stat_min,
    output logic [ils_pkg::READING_W-1:0] o_stat_max,
    output logic [ils_pkg::READING_W-1:0] o_reference_now
);

    localparam int N_W   = $clog2(SAMPLES_MAX + 1);
    localparam int RAW_W = ils_pkg::SAMPLE_W + N_W;
    localparam int Q_W   = RAW_W + ils_pkg::FRAC_W;
    localparam int SUM_W = ils_pkg::READING_W + COUNT_BITS;
    localparam int DEN_W = (COUNT_BITS > N_W) ? COUNT_BITS : N_W;
    localparam int RW    = ils_pkg::READING_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic              reading_ready;
        ils_pkg::t_reading reading;
        logic              track_found;
        logic              stats_ready;
        ils_pkg::t_reading stat_mean;
        ils_pkg::t_reading stat_min;
        ils_pkg::t_reading stat_max;
        ils_pkg::t_reading reference_now;
    } t_result;

    t_state                  r_state, n_state;
    logic [ils_pkg::CFG_W-1:0] r_cfg, n_cfg;
    logic [RAW_W-1:0]        r_raw_sum, n_raw_sum;
    logic [N_W-1:0]          r_raw_count, n_raw_count;
    ils_pkg::t_reading       r_latest, n_latest;
    ils_pkg::t_reading       r_reference, n_reference;
    ils_pkg::t_reading       r_wmin, n_wmin, r_wmax, n_wmax;
    logic [SUM_W-1:0]        r_wsum, n_wsum;
    logic [COUNT_BITS-1:0]   r_wcnt, n_wcnt;
    ils_pkg::t_reading       r_bmin, n_bmin, r_bmax, n_bmax;
    logic [SUM_W-1:0]        r_bsum, n_bsum;
    logic [COUNT_BITS-1:0]   r_bcnt, n_bcnt;
    ils_pkg::t_op            r_op, n_op;
    ils_pkg::t_phase         r_phase, n_phase;
    t_result                 r_pend, n_pend;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    logic [N_W-1:0]              n_use;
    logic [ils_pkg::SAMPLE_W-1:0] smp;
    logic [RAW_W-1:0]            raw_sum_new;
    logic [N_W-1:0]              raw_cnt_new;
    logic [RW:0]                 mid_sum;
    ils_pkg::t_reading           ref_load;

    logic                        div_start;
    logic [DEN_W-1:0]            div_rem;
    logic [Q_W-1:0]              div_num;
    logic [DEN_W-1:0]            div_den;
    logic                        div_done;
    logic [Q_W-1:0]              div_quo;

    ils_div #(
        .DEN_W (DEN_W),
        .QUO_W (Q_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (div_rem),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        if (r_cfg == '0) begin
            n_use = N_W'(1);
        end else if (int'(r_cfg) > SAMPLES_MAX) begin
            n_use = N_W'(SAMPLES_MAX);
        end else begin
            n_use = N_W'(r_cfg);
        end
        smp = (i_sample > ils_pkg::SAMPLE_W'(ils_pkg::ADC_MAX)) ?
              ils_pkg::SAMPLE_W'(ils_pkg::ADC_MAX) : i_sample;
        raw_sum_new = r_raw_sum + RAW_W'(smp);
        raw_cnt_new = r_raw_count + 1'b1;
        mid_sum     = {1'b0, r_wmax} + {1'b0, r_bmin};
        ref_load    = (i_reference_value > RW'(ils_pkg::READING_MAX)) ?
                      RW'(ils_pkg::READING_MAX) : i_reference_value;
    end

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_raw_sum   = r_raw_sum;
        n_raw_count = r_raw_count;
        n_latest    = r_latest;
        n_reference = r_reference;
        n_wmin      = r_wmin;
        n_wmax      = r_wmax;
        n_wsum      = r_wsum;
        n_wcnt      = r_wcnt;
        n_bmin      = r_bmin;
        n_bmax      = r_bmax;
        n_bsum      = r_bsum;
        n_bcnt      = r_bcnt;
        n_op        = r_op;
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_start   = 1'b0;
        div_rem     = '0;
        div_num     = '0;
        div_den     = '0;

        if (i_cfg_we) begin
            n_cfg = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = ils_pkg::t_op'(i_op);
                    n_phase = ils_pkg::t_phase'(i_phase);
                    n_pend  = '{
                        reading_ready: 1'b0,
                        reading:       r_latest,
                        track_found:   1'b0,
                        stats_ready:   1'b0,
                        stat_mean:     '0,
                        stat_min:      '0,
                        stat_max:      '0,
                        reference_now: r_reference
                    };
                    n_state = ST_OUT;
                    unique case (ils_pkg::t_op'(i_op))
                        ils_pkg::OP_SAMPLE: begin
                            if (raw_cnt_new >= n_use) begin
                                n_raw_sum   = '0;
                                n_raw_count = '0;
                                div_start   = 1'b1;
                                div_num     = {raw_sum_new, {ils_pkg::FRAC_W{1'b0}}};
                                div_den     = DEN_W'(n_use);
                                n_state     = ST_DIV;
                            end else begin
                                n_raw_sum   = raw_sum_new;
                                n_raw_count = raw_cnt_new;
                            end
                        end
                        ils_pkg::OP_END_PHASE: begin
                            if (ils_pkg::t_phase'(i_phase) == ils_pkg::PH_WHITE) begin
                                n_pend.stats_ready = 1'b1;
                                n_pend.stat_min    = r_wmin;
                                n_pend.stat_max    = r_wmax;
                                if (r_wcnt != '0) begin
                                    div_start = 1'b1;
                                    div_rem   = DEN_W'(r_wsum >> Q_W);
                                    div_num   = Q_W'(r_wsum);
                                    div_den   = DEN_W'(r_wcnt);
                                    n_state   = ST_DIV;
                                end
                            end else if (ils_pkg::t_phase'(i_phase) == ils_pkg::PH_BLACK) begin
                                n_pend.stats_ready   = 1'b1;
                                n_pend.stat_min      = r_bmin;
                                n_pend.stat_max      = r_bmax;
                                n_reference          = mid_sum[RW:1];
                                n_pend.reference_now = mid_sum[RW:1];
                                if (r_bcnt != '0) begin
                                    div_start = 1'b1;
                                    div_rem   = DEN_W'(r_bsum >> Q_W);
                                    div_num   = Q_W'(r_bsum);
                                    div_den   = DEN_W'(r_bcnt);
                                    n_state   = ST_DIV;
                                end
                                n_wmin = RW'(ils_pkg::READING_MAX);
                                n_wmax = '0;
                                n_wsum = '0;
                                n_wcnt = '0;
                                n_bmin = RW'(ils_pkg::READING_MAX);
                                n_bmax = '0;
                                n_bsum = '0;
                                n_bcnt = '0;
                            end
                        end
                        ils_pkg::OP_LOAD_REF: begin
                            n_reference          = ref_load;
                            n_pend.reference_now = ref_load;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_op == ils_pkg::OP_SAMPLE) begin
                        n_latest = (div_quo > Q_W'(ils_pkg::READING_MAX)) ?
                                   RW'(ils_pkg::READING_MAX) : div_quo[RW-1:0];
                        n_state  = ST_UPD;
                    end else begin
                        n_pend.stat_mean = div_quo[RW-1:0];
                        n_state          = ST_OUT;
                    end
                end
            end
            ST_UPD: begin
                n_pend.reading_ready = 1'b1;
                n_pend.reading       = r_latest;
                unique case (r_phase)
                    ils_pkg::PH_DETECT: begin
                        n_pend.track_found = (r_latest > r_reference);
                    end
                    ils_pkg::PH_WHITE: begin
                        if (r_latest < r_wmin) begin
                            n_wmin = r_latest;
                        end
                        if (r_latest > r_wmax) begin
                            n_wmax = r_latest;
                        end
                        if (r_wcnt != '1) begin
                            n_wsum = r_wsum + SUM_W'(r_latest);
                            n_wcnt = r_wcnt + 1'b1;
                        end
                    end
                    ils_pkg::PH_BLACK: begin
                        if (r_latest < r_bmin) begin
                            n_bmin = r_latest;
                        end
                        if (r_latest > r_bmax) begin
                            n_bmax = r_latest;
                        end
                        if (r_bcnt != '1) begin
                            n_bsum = r_bsum + SUM_W'(r_latest);
                            n_bcnt = r_bcnt + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= ils_pkg::CFG_W'(ils_pkg::CFG_RESET);
            r_raw_sum   <= '0;
            r_raw_count <= '0;
            r_latest    <= '0;
            r_reference <= '0;
            r_wmin      <= RW'(ils_pkg::READING_MAX);
            r_wmax      <= '0;
            r_wsum      <= '0;
            r_wcnt      <= '0;
            r_bmin      <= RW'(ils_pkg::READING_MAX);
            r_bmax      <= '0;
            r_bsum      <= '0;
            r_bcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_raw_sum   <= n_raw_sum;
            r_raw_count <= n_raw_count;
            r_latest    <= n_latest;
            r_reference <= n_reference;
            r_wmin      <= n_wmin;
            r_wmax      <= n_wmax;
            r_wsum      <= n_wsum;
            r_wcnt      <= n_wcnt;
            r_bmin      <= n_bmin;
            r_bmax      <= n_bmax;
            r_bsum      <= n_bsum;
            r_bcnt      <= n_bcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_phase <= n_phase;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_reading_ready = r_out.reading_ready;
    assign o_reading       = r_out.reading;
    assign o_track_found   = r_out.track_found;
    assign o_stats_ready   = r_out.stats_ready;
    assign o_stat_mean     = r_out.stat_mean;
    assign o_stat_min      = r_out.stat_min;
    assign o_stat_max      = r_out.stat_max;
    assign o_reference_now = r_out.reference_now;

endmodule

`default_nettype wire

/* src/ils_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module ils_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [ils_pkg::CFG_W-1:0]     i_cfg_wdata,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [ils_pkg::OP_W-1:0]      i_op,
    input logic [ils_pkg::SAMPLE_W-1:0]  i_sample,
    input logic [ils_pkg::PHASE_W-1:0]   i_phase,
    input logic [ils_pkg::READING_W-1:0] i_reference_value,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_reading_ready,
    input logic [ils_pkg::READING_W-1:0] o_reading,
    input logic                          o_track_found,
    input logic                          o_stats_ready,
    input logic [ils_pkg::READING_W-1:0] o_stat_mean,
    input logic [ils_pkg::READING_W-1:0] o_stat_min,
    input logic [ils_pkg::READING_W-1:0] o_stat_max,
    input logic [ils_pkg::READING_W-1:0] o_reference_now
);

    logic unused_inputs;

    assign unused_inputs = ^{i_cfg_we, i_cfg_wdata, i_in_valid, o_in_ready, i_op,
                             i_sample, i_phase, i_reference_value, o_stat_min};

    `ASSERT_IMP(a_track_above_ref, i_clk, i_rst_n, o_out_valid && o_track_found, o_reading_ready && (o_reading > o_reference_now))

    `ASSERT_IMP(a_stats_zero_idle, i_clk, i_rst_n, o_out_valid && !o_stats_ready, (o_stat_mean == '0) && (o_stat_min == '0) && (o_stat_max == '0))

    `ASSERT_IMP(a_one_kind, i_clk, i_rst_n, o_out_valid, !(o_reading_ready && o_stats_ready))

    `ASSERT_IMP(a_mean_in_range, i_clk, i_rst_n, o_out_valid && o_stats_ready, (o_stat_mean <= o_stat_max) && (o_reference_now <= ils_pkg::READING_W'(ils_pkg::READING_MAX)))

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_reading) && $stable(o_stat_mean) && $stable(o_reference_now))

endmodule

bind ir_line_sensor_calibrate ils_checker u_ils_checker (.*);

`default_nettype wire

/* tb/ir_line_sensor_calibrate_tb.sv */
module ir_line_sensor_calibrate_tb;

    localparam int             OP_W         = ils_pkg::OP_W;
    localparam int             PHASE_W      = ils_pkg::PHASE_W;
    localparam int             SAMPLE_W     = ils_pkg::SAMPLE_W;
    localparam int             CFG_W        = ils_pkg::CFG_W;
    localparam int             READING_W    = ils_pkg::READING_W;
    localparam int             READING_MAX  = ils_pkg::READING_MAX;
    localparam int             CFG_RESET    = ils_pkg::CFG_RESET;
    localparam ils_pkg::t_op    OP_SAMPLE    = ils_pkg::OP_SAMPLE;
    localparam ils_pkg::t_op    OP_END_PHASE = ils_pkg::OP_END_PHASE;
    localparam ils_pkg::t_op    OP_LOAD_REF  = ils_pkg::OP_LOAD_REF;
    localparam ils_pkg::t_phase PH_DETECT    = ils_pkg::PH_DETECT;
    localparam ils_pkg::t_phase PH_WHITE     = ils_pkg::PH_WHITE;
    localparam ils_pkg::t_phase PH_BLACK     = ils_pkg::PH_BLACK;

    typedef ils_pkg::t_reading t_reading;

    localparam logic [OP_W-1:0]    OP_IGNORED   = 2'd3;
    localparam logic [PHASE_W-1:0] PH_NONE      = 2'd3;
    localparam int                 SAMPLES_MAX  = 64;
    localparam int                 RANDOM_ITEMS = 1100;
    localparam int                 CYCLE_LIMIT  = 1000000;
    localparam int                 DRAIN_CYCLES = 40;
    localparam t_reading           RMAX         = t_reading'(READING_MAX);
    localparam t_reading           RMAX_HALF    = t_reading'(READING_MAX / 2);
    localparam t_reading           REF_TOP      = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_TOP  = '1;

    typedef struct packed {
        logic     ready;
        t_reading reading;
        logic     track;
        logic     sready;
        t_reading mean;
        t_reading lo;
        t_reading hi;
        t_reading refnow;
    } t_sensor_report;

    typedef struct packed {
        t_reading    lo;
        t_reading    hi;
        logic [33:0] total;
        logic [19:0] cnt;
    } t_band;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_W-1:0]     cfg;
        logic [OP_W-1:0]      op;
        logic [SAMPLE_W-1:0]  smp;
        logic [PHASE_W-1:0]   ph;
        t_reading             rv;
        bit                   typed;
        t_sensor_report       want;
    } t_plan_row;

    localparam t_band BAND_CLEAR = '{lo: RMAX, hi: '0, total: '0, cnt: '0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op;
    logic [SAMPLE_W-1:0]  i_sample;
    logic [PHASE_W-1:0]   i_phase;
    t_reading             i_reference_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_reading_ready;
    t_reading             o_reading;
    logic                 o_track_found;
    logic                 o_stats_ready;
    t_reading             o_stat_mean;
    t_reading             o_stat_min;
    t_reading             o_stat_max;
    t_reading             o_reference_now;

    // prediction state
    logic [CFG_W-1:0] group_cfg;
    int unsigned      raw_acc;
    int unsigned      raw_seen;
    t_reading         latest;
    t_reading         thresh;
    t_band            band [1:2];

    t_sensor_report   sensor_reports [$];
    t_plan_row        stimulus_plan [$];
    bit               req_typed;
    t_sensor_report   req_want;
    bit               tx_calm;
    bit               rx_calm;
    int unsigned      requests_sent;
    int unsigned      fault_count;
    int unsigned      cycle_count;

    ir_line_sensor_calibrate u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_sample          (i_sample),
        .i_phase           (i_phase),
        .i_reference_value (i_reference_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_reading_ready   (o_reading_ready),
        .o_reading         (o_reading),
        .o_track_found     (o_track_found),
        .o_stats_ready     (o_stats_ready),
        .o_stat_mean       (o_stat_mean),
        .o_stat_min        (o_stat_min),
        .o_stat_max        (o_stat_max),
        .o_reference_now   (o_reference_now)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned group_size();
        if (group_cfg == '0) return 1;
        if (int'(group_cfg) > SAMPLES_MAX) return SAMPLES_MAX;
        return int'(group_cfg);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic sensor_step(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                               input logic [PHASE_W-1:0] ph, input t_reading rv,
                               output t_sensor_report r);
        int unsigned n;
        int unsigned q;
        r = '0;
        n = group_size();
        case (op)
            OP_SAMPLE: begin
                raw_acc += smp;
                raw_seen += 1;
                if (raw_seen >= n) begin
                    q = (raw_acc * 16) / n;
                    latest = (q > READING_MAX) ? RMAX : t_reading'(q);
                    raw_acc = 0;
                    raw_seen = 0;
                    r.ready = 1'b1;
                    if (ph == PH_DETECT) begin
                        r.track = (latest > thresh);
                    end else if (ph == PH_WHITE || ph == PH_BLACK) begin
                        if (latest < band[ph].lo) band[ph].lo = latest;
                        if (latest > band[ph].hi) band[ph].hi = latest;
                        if (band[ph].cnt != '1) begin
                            band[ph].total += latest;
                            band[ph].cnt += 1'b1;
                        end
                    end
                end
            end
            OP_END_PHASE: begin
                if (ph == PH_WHITE || ph == PH_BLACK) begin
                    r.sready = 1'b1;
                    r.mean = (band[ph].cnt == '0) ? '0
                             : t_reading'(band[ph].total / band[ph].cnt);
                    r.lo = band[ph].lo;
                    r.hi = band[ph].hi;
                    if (ph == PH_BLACK) begin
                        thresh = t_reading'((int'(band[PH_WHITE].hi)
                                             + int'(band[PH_BLACK].lo)) / 2);
                        band[PH_WHITE] = BAND_CLEAR;
                        band[PH_BLACK] = BAND_CLEAR;
                    end
                end
            end
            OP_LOAD_REF: begin
                thresh = (rv > RMAX) ? RMAX : rv;
            end
            default: begin
            end
        endcase
        r.reading = latest;
        r.refnow = thresh;
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic compare_field(input string name, input logic [READING_W-1:0] got,
                                 input logic [READING_W-1:0] want);
        if (got !== want) note_fault($sformatf("%s got %0d, wanted %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch
        t_sensor_report got;
        t_sensor_report want;
        t_sensor_report fresh;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_reading_ready, o_reading, o_track_found, o_stats_ready,
                        o_stat_mean, o_stat_min, o_stat_max, o_reference_now};
                if (sensor_reports.size() == 0) begin
                    note_fault("result with no request outstanding");
                end else begin
                    want = sensor_reports.pop_front();
                    compare_field("reading_ready", got.ready, want.ready);
                    compare_field("reading", got.reading, want.reading);
                    compare_field("track_found", got.track, want.track);
                    compare_field("stats_ready", got.sready, want.sready);
                    compare_field("stat_mean", got.mean, want.mean);
                    compare_field("stat_min", got.lo, want.lo);
                    compare_field("stat_max", got.hi, want.hi);
                    compare_field("reference_now", got.refnow, want.refnow);
                end
            end
            if (i_in_valid && o_in_ready) begin
                sensor_step(i_op, i_sample, i_phase, i_reference_value, fresh);
                sensor_reports.push_back(req_typed ? req_want : fresh);
            end
        end
    end

    initial begin : result_sink
        int unsigned hold;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = rx_calm ? 0 : pick_gap();
            if (hold == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                                input logic [PHASE_W-1:0] ph, input t_reading rv,
                                input bit typed, input t_sensor_report want);
        int unsigned gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_sample          <= smp;
        i_phase           <= ph;
        i_reference_value <= rv;
        req_typed         <= typed;
        req_want          <= want;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (op != OP_IGNORED) requests_sent++;
    endtask

    // drop the request line and hold until every result has been taken
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sensor_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_group_size(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        group_cfg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_noise();
        send_request(OP_W'($urandom_range(0, 3)), SAMPLE_W'($urandom_range(0, 1023)),
                     PHASE_W'($urandom_range(0, 3)), READING_W'($urandom_range(0, 16383)),
                     1'b0, '0);
    endtask

    task automatic send_reading(input logic [PHASE_W-1:0] ph, input int unsigned lo,
                                input int unsigned hi);
        repeat (group_size()) begin
            if ($urandom_range(0, 24) == 0) send_noise();
            send_request(OP_SAMPLE, SAMPLE_W'($urandom_range(lo, hi)), ph,
                         READING_W'($urandom_range(0, 16383)), 1'b0, '0);
        end
    endtask

    task automatic run_session();
        int unsigned cap;
        cap = (group_size() > 16) ? 1 : 3;
        repeat ($urandom_range(0, cap)) send_reading(PH_WHITE, 600, 1023);
        send_request(OP_END_PHASE, SAMPLE_W'($urandom_range(0, 1023)), PH_WHITE,
                     READING_W'($urandom_range(0, 16383)), 1'b0, '0);
        repeat ($urandom_range(0, cap)) send_reading(PH_BLACK, 0, 420);
        send_request(OP_END_PHASE, SAMPLE_W'($urandom_range(0, 1023)), PH_BLACK,
                     READING_W'($urandom_range(0, 16383)), 1'b0, '0);
        repeat ($urandom_range(1, cap + 1)) begin
            if ($urandom_range(0, 5) == 0) begin
                send_request(OP_LOAD_REF, SAMPLE_W'($urandom_range(0, 1023)),
                             PHASE_W'($urandom_range(0, 3)),
                             READING_W'($urandom_range(0, 16383)), 1'b0, '0);
            end
            send_reading(PH_DETECT, 0, 1023);
        end
    endtask

    task automatic plan_req(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                            input logic [PHASE_W-1:0] ph, input t_reading rv,
                            input bit typed, input t_sensor_report want);
        stimulus_plan.push_back('{1'b0, '0, op, smp, ph, rv, typed, want});
    endtask

    task automatic plan_cfg(input logic [CFG_W-1:0] value);
        stimulus_plan.push_back('{1'b1, value, '0, '0, '0, '0, 1'b0, '0});
    endtask

    initial begin : stimulus
        int unsigned random_start;
        int unsigned pick;
        logic [CFG_W-1:0] cfg_next;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_op              = '0;
        i_sample          = '0;
        i_phase           = '0;
        i_reference_value = '0;
        req_typed         = 1'b0;
        req_want          = '0;
        tx_calm           = 1'b0;
        rx_calm           = 1'b0;
        requests_sent     = 0;
        fault_count       = 0;
        cycle_count       = 0;
        group_cfg         = CFG_W'(CFG_RESET);
        raw_acc           = 0;
        raw_seen          = 0;
        latest            = '0;
        thresh            = '0;
        band[PH_WHITE]    = BAND_CLEAR;
        band[PH_BLACK]    = BAND_CLEAR;

        plan_req(OP_IGNORED, SAMPLE_TOP, PH_NONE, REF_TOP, 1'b1, '0);
        plan_req(OP_END_PHASE, '0, PH_WHITE, '0, 1'b1,
                 '{1'b0, '0, 1'b0, 1'b1, '0, RMAX, '0, '0});
        plan_req(OP_END_PHASE, '0, PH_DETECT, '0, 1'b1, '0);
        plan_req(OP_END_PHASE, '0, PH_NONE, '0, 1'b1, '0);
        plan_req(OP_LOAD_REF, '0, PH_DETECT, REF_TOP, 1'b1,
                 '{1'b0, '0, 1'b0, 1'b0, '0, '0, '0, RMAX});
        plan_req(OP_LOAD_REF, SAMPLE_TOP, PH_BLACK, '0, 1'b1, '0);
        repeat (7) plan_req(OP_SAMPLE, SAMPLE_TOP, PH_DETECT, '0, 1'b0, '0);
        plan_req(OP_SAMPLE, SAMPLE_TOP, PH_DETECT, '0, 1'b1,
                 '{1'b1, RMAX, 1'b1, 1'b0, '0, '0, '0, '0});
        plan_cfg('0);
        plan_req(OP_SAMPLE, '0, PH_WHITE, '0, 1'b1,
                 '{1'b1, '0, 1'b0, 1'b0, '0, '0, '0, '0});
        plan_req(OP_SAMPLE, SAMPLE_TOP, PH_BLACK, '0, 1'b1,
                 '{1'b1, RMAX, 1'b0, 1'b0, '0, '0, '0, '0});
        plan_req(OP_END_PHASE, '0, PH_WHITE, '0, 1'b1,
                 '{1'b0, RMAX, 1'b0, 1'b1, '0, '0, '0, '0});
        plan_req(OP_END_PHASE, '0, PH_BLACK, '0, 1'b1,
                 '{1'b0, RMAX, 1'b0, 1'b1, RMAX, RMAX, RMAX, RMAX_HALF});
        plan_req(OP_END_PHASE, '0, PH_WHITE, '0, 1'b1,
                 '{1'b0, RMAX, 1'b0, 1'b1, '0, RMAX, '0, RMAX_HALF});
        plan_req(OP_SAMPLE, 10'd512, PH_NONE, '0, 1'b0, '0);
        plan_req(OP_SAMPLE, 10'd1, PH_DETECT, '0, 1'b0, '0);
        plan_cfg('1);
        repeat (3) plan_req(OP_SAMPLE, SAMPLE_TOP, PH_DETECT, '0, 1'b0, '0);
        // lower the group size below the partial group
        plan_cfg(7'd2);
        plan_req(OP_SAMPLE, SAMPLE_TOP, PH_DETECT, '0, 1'b1,
                 '{1'b1, RMAX, 1'b1, 1'b0, '0, '0, '0, RMAX_HALF});

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stimulus_plan[i]) begin
            if (stimulus_plan[i].is_cfg) begin
                write_group_size(stimulus_plan[i].cfg);
            end else begin
                send_request(stimulus_plan[i].op, stimulus_plan[i].smp, stimulus_plan[i].ph,
                             stimulus_plan[i].rv, stimulus_plan[i].typed,
                             stimulus_plan[i].want);
            end
        end

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       cfg_next = '0;
                1:       cfg_next = '1;
                2:       cfg_next = CFG_W'(SAMPLES_MAX);
                3:       cfg_next = CFG_W'($urandom_range(SAMPLES_MAX + 1, 126));
                default: begin
                    if (pick < 10) cfg_next = CFG_W'($urandom_range(1, 4));
                    else if (pick < 16) cfg_next = CFG_W'($urandom_range(5, 8));
                    else cfg_next = CFG_W'($urandom_range(9, 16));
                end
            endcase
            write_group_size(cfg_next);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat (20) send_noise();
            end else begin
                run_session();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
